@@ hdl/descriptor_loop_splitter_assert.svh @@
// Assertion macros used by the descriptor loop splitter checker.
`ifndef DESCRIPTOR_LOOP_SPLITTER_ASSERT_SVH
`define DESCRIPTOR_LOOP_SPLITTER_ASSERT_SVH

// Same-cycle implication, sampled on clock, off during reset.
`define DLS_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("descriptor loop splitter check failed");

// Next-cycle implication, sampled on clock, off during reset.
`define DLS_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("descriptor loop splitter check failed");

`endif

@@ hdl/dls_pkg.sv @@
// Shared types and constants of the descriptor loop splitter.
package dls_pkg;

   localparam int MAX_LOOP_BYTES = 4096;
   localparam logic [11:0] CNT_MAX = 12'(MAX_LOOP_BYTES / 2);
   localparam logic [7:0] EXT_TAG = 8'h7f;

   // Parser phase codes
   localparam logic [1:0] PH_TAG = 2'd0;
   localparam logic [1:0] PH_LEN = 2'd1;
   localparam logic [1:0] PH_PAY = 2'd2;

   // Byte role codes
   localparam logic [1:0] ROLE_TAG = 2'd0;
   localparam logic [1:0] ROLE_LEN = 2'd1;
   localparam logic [1:0] ROLE_EXT = 2'd2;
   localparam logic [1:0] ROLE_PAY = 2'd3;

   // List status codes
   localparam logic [1:0] ST_OK = 2'd0;
   localparam logic [1:0] ST_TRUNC = 2'd1;
   localparam logic [1:0] ST_PAST = 2'd2;

   // Register indexes
   localparam logic CSR_TARGET_TAG = 1'b0;
   localparam logic CSR_MATCH_ENABLE = 1'b1;

   typedef struct packed {
      logic [7:0] target_tag;
      logic       match_enable;
   } dls_cfg_type;

   typedef struct packed {
      logic [1:0]  byte_role;
      logic [7:0]  tag;
      logic [7:0]  extension_tag;
      logic [7:0]  descriptor_length;
      logic [7:0]  payload_offset;
      logic [10:0] descriptor_index;
      logic        descriptor_done;
      logic        is_first_match;
      logic        list_done;
      logic [1:0]  status;
      logic [11:0] descriptor_count;
      logic        match_found;
   } dls_result_type;

endpackage

@@ hdl/dls_core.sv @@
// Descriptor loop parser state and per-word labeling logic.
module dls_core
   import dls_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           advance,
   input  logic [7:0]     data_byte,
   input  logic           last_byte,
   input  dls_cfg_type    cfg,
   output dls_result_type result
);

   logic [1:0]  phase_ff, phase_in;
   logic [7:0]  remain_ff, remain_in;
   logic [7:0]  tag_ff, tag_in;
   logic [7:0]  length_ff, length_in;
   logic [7:0]  offset_ff, offset_in;
   logic [7:0]  ext_ff, ext_in;
   logic [11:0] count_ff, count_in;
   logic        found_ff, found_in;
   logic        match_ff, match_in;

   logic [7:0]  remain_dec;
   logic [11:0] count_dec;

   // Label the word and work out the parser's next state
   always_comb begin
      phase_in  = phase_ff;
      remain_in = remain_ff;
      tag_in    = tag_ff;
      length_in = length_ff;
      offset_in = offset_ff;
      ext_in    = ext_ff;
      count_in  = count_ff;
      found_in  = found_ff;
      match_in  = match_ff;
      remain_dec = remain_ff - 8'd1;
      result = '0;

      case (phase_ff)
         PH_LEN: begin
            result.byte_role = ROLE_LEN;
            length_in = data_byte;
            remain_in = data_byte;
            result.descriptor_length = data_byte;
            if (data_byte == 8'd0) begin
               result.descriptor_done = 1'b1;
               phase_in = PH_TAG;
               result.status = ST_OK;
            end else begin
               phase_in = PH_PAY;
               result.status = ST_PAST;
            end
         end
         PH_PAY: begin
            if (tag_ff == EXT_TAG && offset_ff == 8'd0) begin
               result.byte_role = ROLE_EXT;
               ext_in = data_byte;
            end else begin
               result.byte_role = ROLE_PAY;
            end
            result.descriptor_length = length_ff;
            result.payload_offset = offset_ff;
            offset_in = offset_ff + 8'd1;
            remain_in = remain_dec;
            if (remain_dec == 8'd0) begin
               result.descriptor_done = 1'b1;
               phase_in = PH_TAG;
               result.status = ST_OK;
            end else begin
               result.status = ST_PAST;
            end
         end
         default: begin
            // Tag word: open a new descriptor
            result.byte_role = ROLE_TAG;
            tag_in    = data_byte;
            length_in = 8'd0;
            offset_in = 8'd0;
            ext_in    = 8'd0;
            remain_in = 8'd0;
            if (count_ff < CNT_MAX) begin
               count_in = count_ff + 12'd1;
            end
            match_in = cfg.match_enable && (data_byte == cfg.target_tag) && !found_ff;
            if (match_in) begin
               found_in = 1'b1;
            end
            phase_in = PH_LEN;
            result.status = ST_TRUNC;
         end
      endcase

      if (!last_byte) begin
         result.status = ST_OK;
      end

      count_dec = (count_in == 12'd0) ? 12'd0 : count_in - 12'd1;
      result.tag              = tag_in;
      result.extension_tag    = ext_in;
      result.descriptor_index = count_dec[10:0];
      result.is_first_match   = match_in;
      result.list_done        = last_byte;
      result.descriptor_count = count_in;
      result.match_found      = found_in;

      // Drop all loop state after the final word
      if (last_byte) begin
         phase_in  = PH_TAG;
         remain_in = 8'd0;
         tag_in    = 8'd0;
         length_in = 8'd0;
         offset_in = 8'd0;
         ext_in    = 8'd0;
         count_in  = 12'd0;
         found_in  = 1'b0;
         match_in  = 1'b0;
      end
   end

   // Advance the parser state once per processed word
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_TAG;
         remain_ff <= 8'd0;
         tag_ff    <= 8'd0;
         length_ff <= 8'd0;
         offset_ff <= 8'd0;
         ext_ff    <= 8'd0;
         count_ff  <= 12'd0;
         found_ff  <= 1'b0;
         match_ff  <= 1'b0;
      end else if (advance) begin
         phase_ff  <= phase_in;
         remain_ff <= remain_in;
         tag_ff    <= tag_in;
         length_ff <= length_in;
         offset_ff <= offset_in;
         ext_ff    <= ext_in;
         count_ff  <= count_in;
         found_ff  <= found_in;
         match_ff  <= match_in;
      end
   end

endmodule

@@ hdl/descriptor_loop_splitter.sv @@
// Top level of the descriptor loop splitter.
//
// Takes one byte of an MPEG-TS descriptor loop per req_ word (req_last_byte
// marks the final byte) and returns exactly one rsp_ word per byte: its role
// (tag, length, extension tag, payload), the descriptor it belongs to, and at
// the final byte the descriptor count, match flag and list status.
// A nonzero status means the list is broken and should be dropped whole.
// A byte accepted into the input register is labeled there and shows on rsp_
// once the result register has taken it.
// Throughput: one byte per cycle while rsp_ready stays high; the input register
// and the result register each hold one word, and the parser state updates with the result register.
// When rsp_ready is low the result register holds, the input register fills,
// and req_ready drops until the result is taken.
// Reset clears the parser state, the valid flags of both registers and the csr_ registers.
// The parser state also returns to its reset value after each final byte.
// csr_ writes (index 0 target tag, 1 match enable) are registered; the user
// must make them only while no byte is in flight, which the block does not enforce.
module descriptor_loop_splitter
   import dls_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_last_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_byte_role,
   output logic [7:0]  rsp_tag,
   output logic [7:0]  rsp_extension_tag,
   output logic [7:0]  rsp_descriptor_length,
   output logic [7:0]  rsp_payload_offset,
   output logic [10:0] rsp_descriptor_index,
   output logic        rsp_descriptor_done,
   output logic        rsp_is_first_match,
   output logic        rsp_list_done,
   output logic [1:0]  rsp_status,
   output logic [11:0] rsp_descriptor_count,
   output logic        rsp_match_found,
   input  logic        csr_write_enable,
   input  logic        csr_index,
   input  logic [7:0]  csr_wdata
);

   dls_cfg_type    cfg_ff;
   logic           in_valid_ff;
   logic [7:0]     in_data_ff;
   logic           in_last_ff;
   logic           out_valid_ff;
   dls_result_type out_ff;
   dls_result_type result;
   logic           advance;

   // Move a word forward when the result register is free or being taken
   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_TARGET_TAG:   cfg_ff.target_tag   <= csr_wdata;
            CSR_MATCH_ENABLE: cfg_ff.match_enable <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_data_ff <= req_data_byte;
         in_last_ff <= req_last_byte;
      end
   end

   dls_core u_core (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .data_byte (in_data_ff),
      .last_byte (in_last_ff),
      .cfg       (cfg_ff),
      .result    (result)
   );

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_ff <= result;
      end
   end

   assign rsp_valid             = out_valid_ff;
   assign rsp_byte_role         = out_ff.byte_role;
   assign rsp_tag               = out_ff.tag;
   assign rsp_extension_tag     = out_ff.extension_tag;
   assign rsp_descriptor_length = out_ff.descriptor_length;
   assign rsp_payload_offset    = out_ff.payload_offset;
   assign rsp_descriptor_index  = out_ff.descriptor_index;
   assign rsp_descriptor_done   = out_ff.descriptor_done;
   assign rsp_is_first_match    = out_ff.is_first_match;
   assign rsp_list_done         = out_ff.list_done;
   assign rsp_status            = out_ff.status;
   assign rsp_descriptor_count  = out_ff.descriptor_count;
   assign rsp_match_found       = out_ff.match_found;

endmodule

@@ hdl/dls_checker.sv @@
// Port-level checks for the descriptor loop splitter, bound to the top level.
`include "descriptor_loop_splitter_assert.svh"

module dls_checker
   import dls_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [1:0]  rsp_byte_role,
   input logic [7:0]  rsp_tag,
   input logic [7:0]  rsp_descriptor_length,
   input logic [7:0]  rsp_payload_offset,
   input logic        rsp_is_first_match,
   input logic        rsp_list_done,
   input logic [1:0]  rsp_status,
   input logic [11:0] rsp_descriptor_count,
   input logic        rsp_match_found
);

   logic [21:0] held_fields;

   assign held_fields = {rsp_tag, rsp_descriptor_count, rsp_status};

   // A stalled result word holds
   `DLS_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(held_fields))

   // Status is only reported on the final word
   `DLS_ASSERT_NOW(a_status_at_end, rsp_valid && !rsp_list_done, rsp_status == ST_OK)

   // A tag word carries no length and no offset yet
   `DLS_ASSERT_NOW(a_tag_fresh, rsp_valid && rsp_byte_role == ROLE_TAG, rsp_descriptor_length == 8'd0 && rsp_payload_offset == 8'd0)

   // A word of the first match implies the match was seen
   `DLS_ASSERT_NOW(a_match_seen, rsp_valid && rsp_is_first_match, rsp_match_found && rsp_descriptor_count != 12'd0)

endmodule

bind descriptor_loop_splitter dls_checker u_dls_checker (.*);
